// ===== design/track_box_gap_fill_and_segment_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the track box gap fill and segment block
// Shared concurrent assertion forms, clocked on clk_i, off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TRACK_BOX_GAP_FILL_AND_SEGMENT_TOP_ASSERT_SVH
`define TRACK_BOX_GAP_FILL_AND_SEGMENT_TOP_ASSERT_SVH

// Check that cond implies prop in the same cycle.
`define TBGF_ASSERT_SAME(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Check that cond implies prop in the following cycle.
`define TBGF_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== design/tbgf_pkg.sv =====
// ----------------------------------------------------------------------------
// tbgf_pkg
// Types, constants and helpers shared by the track box gap fill blocks.
// ----------------------------------------------------------------------------
package tbgf_pkg;

  // Internal coordinate width, wide enough for filled and clipped boxes.
  localparam int unsigned VW         = 20;
  localparam int unsigned BOX_W      = 14;
  localparam int unsigned IN_COORD_W = 16;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned FNUM_W     = 21;
  localparam int unsigned RSTART_W   = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [BOX_W-1:0] FRAME_WIDTH_RST  = 14'd1920;
  localparam logic [BOX_W-1:0] FRAME_HEIGHT_RST = 14'd1080;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH     = 3'd0,
    CFG_FRAME_HEIGHT    = 3'd1,
    CFG_RANGE_START     = 3'd2,
    CFG_KEEP_UNCLAMPED  = 3'd3,
    CFG_INVERT_POSITION = 3'd4
  } tbgf_cfg_reg_e;

  typedef logic signed [VW-1:0] coord_t;

  typedef struct packed {
    logic [BOX_W-1:0]    frame_width;
    logic [BOX_W-1:0]    frame_height;
    logic [RSTART_W-1:0] range_start;
    logic                keep_unclamped;
    logic                invert_position;
  } tbgf_cfg_t;

  // One held box; mx/my are the precomputed centers, used for gap filling.
  typedef struct packed {
    coord_t           x;
    coord_t           y;
    coord_t           mx;
    coord_t           my;
    logic [BOX_W-1:0] w;
    logic [BOX_W-1:0] h;
    logic             found;
    logic             interp;
  } tbgf_box_t;

  typedef struct packed {
    tbgf_box_t box;
    logic      last;
  } tbgf_item_t;

  // Result descriptor handed from the window to the emit pipeline.
  typedef struct packed {
    coord_t            x;
    coord_t            y;
    logic [BOX_W-1:0]  w;
    logic [BOX_W-1:0]  h;
    logic [FNUM_W-1:0] fnum;
    logic              fo;
    logic              interp;
    logic              run_start;
    logic              run_end;
    logic              last;
  } tbgf_desc_t;

  // Clipped box: sizes and doubled centers.
  typedef struct packed {
    coord_t            cw;
    coord_t            ch;
    coord_t            sx2;
    coord_t            sy2;
    logic [FNUM_W-1:0] fnum;
    logic              fo;
    logic              interp;
    logic              run_start;
    logic              run_end;
    logic              last;
  } tbgf_clip_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] center_x;
    logic signed [OUT_W-1:0] center_y;
    logic signed [OUT_W-1:0] width;
    logic signed [OUT_W-1:0] height;
    logic signed [OUT_W-1:0] scale;
    logic [FNUM_W-1:0]       frame_number;
    logic                    found_out;
    logic                    interpolated;
    logic                    run_start;
    logic                    run_end;
    logic                    last_out;
  } tbgf_res_t;

  // Halve, truncating toward zero.
  function automatic coord_t half_tz(coord_t v);
    coord_t t;
    t = v + coord_t'({1'b0, v[VW-1]});
    return t >>> 1;
  endfunction

  // Center of a segment with start a and length len.
  function automatic coord_t mid_of(coord_t a, logic [BOX_W-1:0] len);
    coord_t l;
    l = coord_t'({1'b0, len});
    return half_tz((a <<< 1) + l);
  endfunction

endpackage

// ===== design/tbgf_if.sv =====
// ----------------------------------------------------------------------------
// tbgf channel interfaces
// Valid/ready channels for input boxes, results and configuration writes.
// ----------------------------------------------------------------------------
interface tbgf_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [tbgf_pkg::IN_COORD_W-1:0]    box_x;
  logic signed [tbgf_pkg::IN_COORD_W-1:0]    box_y;
  logic [tbgf_pkg::BOX_W-1:0]                box_w;
  logic [tbgf_pkg::BOX_W-1:0]                box_h;
  logic                                      found;
  logic                                      last;

  modport source (output valid, box_x, box_y, box_w, box_h, found, last, input ready);
  modport sink   (input valid, box_x, box_y, box_w, box_h, found, last, output ready);
endinterface

interface tbgf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tbgf_pkg::OUT_W-1:0]    center_x;
  logic signed [tbgf_pkg::OUT_W-1:0]    center_y;
  logic signed [tbgf_pkg::OUT_W-1:0]    width;
  logic signed [tbgf_pkg::OUT_W-1:0]    height;
  logic signed [tbgf_pkg::OUT_W-1:0]    scale;
  logic [tbgf_pkg::FNUM_W-1:0]          frame_number;
  logic                                 found_out;
  logic                                 interpolated;
  logic                                 run_start;
  logic                                 run_end;
  logic                                 last_out;

  modport source (output valid, center_x, center_y, width, height, scale, frame_number,
                  found_out, interpolated, run_start, run_end, last_out, input ready);
  modport sink   (input valid, center_x, center_y, width, height, scale, frame_number,
                  found_out, interpolated, run_start, run_end, last_out, output ready);
endinterface

interface tbgf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tbgf_pkg::CFG_IDX_W-1:0]    index;
  logic [tbgf_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/tbgf_window.sv =====
// ----------------------------------------------------------------------------
// tbgf_window
// Three-frame window: single-gap filling, run marks and end-of-sequence flush.
// ----------------------------------------------------------------------------
`include "track_box_gap_fill_and_segment_top_assert.svh"

module tbgf_window #(
  parameter int unsigned INDEX_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tbgf_pkg::tbgf_cfg_t  cfg_i,
  input  logic                 item_valid_i,
  input  tbgf_pkg::tbgf_item_t item_i,
  output logic                 item_ready_o,
  output logic                 desc_valid_o,
  output tbgf_pkg::tbgf_desc_t desc_o,
  input  logic                 desc_ready_i
);

  localparam int unsigned IDX_LO =
    (INDEX_BITS < tbgf_pkg::FNUM_W) ? INDEX_BITS : tbgf_pkg::FNUM_W;

  tbgf_pkg::tbgf_box_t  held_q [2];
  logic [INDEX_BITS-1:0] idx_q [2];
  logic [1:0]            held_count_q;
  logic [1:0]            flush_cnt_q;
  logic                  ef_q;
  logic [INDEX_BITS-1:0] frame_index_q;
  logic                  desc_vld_q;
  tbgf_pkg::tbgf_desc_t  desc_q;
  tbgf_pkg::tbgf_desc_t  desc_d;

  logic                  d_ready, flushing, take, window_full, fill;
  logic                  emit_norm, emit_flush, d_load;
  logic                  fo0, fo1, succ;
  tbgf_pkg::tbgf_box_t   filled, mid1;
  logic [tbgf_pkg::BOX_W:0] sum_w, sum_h;

  assign d_ready      = !desc_vld_q || desc_ready_i;
  assign flushing     = flush_cnt_q != 2'd0;
  assign item_ready_o = !flushing && d_ready;
  assign take         = item_valid_i && item_ready_o;
  assign window_full  = held_count_q == 2'd2;
  assign fill = window_full && held_q[0].found && !held_q[1].found && item_i.box.found;

  // Average of the two neighbours; the filled box never serves as a neighbour.
  always_comb begin
    sum_w         = {1'b0, held_q[0].w} + {1'b0, item_i.box.w};
    sum_h         = {1'b0, held_q[0].h} + {1'b0, item_i.box.h};
    filled        = held_q[1];
    filled.w      = sum_w[tbgf_pkg::BOX_W:1];
    filled.h      = sum_h[tbgf_pkg::BOX_W:1];
    filled.x      = tbgf_pkg::half_tz(held_q[0].mx + item_i.box.mx)
                    - tbgf_pkg::coord_t'({2'b0, sum_w[tbgf_pkg::BOX_W:2]});
    filled.y      = tbgf_pkg::half_tz(held_q[0].my + item_i.box.my)
                    - tbgf_pkg::coord_t'({2'b0, sum_h[tbgf_pkg::BOX_W:2]});
    filled.interp = 1'b1;
    mid1          = fill ? filled : held_q[1];
  end

  assign fo0        = held_q[0].found || held_q[0].interp;
  assign fo1        = mid1.found || mid1.interp;
  assign emit_norm  = take && window_full;
  assign emit_flush = flushing && d_ready;
  assign d_load     = emit_norm || emit_flush;
  assign succ       = emit_norm ? fo1 : ((flush_cnt_q == 2'd2) && fo1);

  always_comb begin
    desc_d.x         = held_q[0].x;
    desc_d.y         = held_q[0].y;
    desc_d.w         = held_q[0].w;
    desc_d.h         = held_q[0].h;
    desc_d.fnum      = tbgf_pkg::FNUM_W'(idx_q[0][IDX_LO-1:0])
                       + tbgf_pkg::FNUM_W'(cfg_i.range_start);
    desc_d.fo        = fo0;
    desc_d.interp    = held_q[0].interp;
    desc_d.run_start = fo0 && !ef_q;
    desc_d.run_end   = fo0 && !succ;
    desc_d.last      = emit_flush && (flush_cnt_q == 2'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q  <= 2'd0;
      flush_cnt_q   <= 2'd0;
      ef_q          <= 1'b0;
      frame_index_q <= '0;
      desc_vld_q    <= 1'b0;
    end else begin
      if (take) begin
        if (item_i.last) begin
          frame_index_q <= '0;
          held_count_q  <= 2'd0;
          flush_cnt_q   <= window_full ? 2'd2 : 2'(held_count_q + 2'd1);
        end else begin
          frame_index_q <= frame_index_q + INDEX_BITS'(1);
          held_count_q  <= window_full ? 2'd2 : 2'(held_count_q + 2'd1);
        end
      end else if (emit_flush) begin
        flush_cnt_q <= 2'(flush_cnt_q - 2'd1);
      end
      if (d_load) begin
        ef_q <= desc_d.last ? 1'b0 : fo0;
      end
      if (d_load) begin
        desc_vld_q <= 1'b1;
      end else if (desc_ready_i) begin
        desc_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_load) begin
      desc_q <= desc_d;
    end
    if (take) begin
      if (window_full) begin
        held_q[0] <= mid1;
        idx_q[0]  <= idx_q[1];
        held_q[1] <= item_i.box;
        idx_q[1]  <= frame_index_q;
      end else if (held_count_q == 2'd0) begin
        held_q[0] <= item_i.box;
        idx_q[0]  <= frame_index_q;
      end else begin
        held_q[1] <= item_i.box;
        idx_q[1]  <= frame_index_q;
      end
    end else if (emit_flush) begin
      held_q[0] <= held_q[1];
      idx_q[0]  <= idx_q[1];
    end
  end

  assign desc_valid_o = desc_vld_q;
  assign desc_o       = desc_q;

  `TBGF_ASSERT_SAME(a_no_take_in_flush, flushing, !take, "item taken during flush")
  `TBGF_ASSERT_NEXT(a_last_starts_flush, take && item_i.last, flush_cnt_q != 2'd0,
                    "last item did not start a flush")
  `TBGF_ASSERT_SAME(a_count_range, 1'b1, held_count_q != 2'd3, "held count out of range")
  `TBGF_ASSERT_NEXT(a_flush_end_clears, emit_flush && (flush_cnt_q == 2'd1),
                    !ef_q && (held_count_q == 2'd0), "flush end left state behind")

endmodule

// ===== design/tbgf_emit.sv =====
// ----------------------------------------------------------------------------
// tbgf_emit
// Two-stage result path: clip to frame, then center, negate and saturate.
// ----------------------------------------------------------------------------
module tbgf_emit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tbgf_pkg::tbgf_cfg_t  cfg_i,
  input  logic                 desc_valid_i,
  input  tbgf_pkg::tbgf_desc_t desc_i,
  output logic                 desc_ready_o,
  tbgf_out_if.source           res_o
);

  localparam int unsigned SW =
    (COORD_BITS > tbgf_pkg::VW) ? COORD_BITS : tbgf_pkg::VW;
  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  typedef struct packed {
    tbgf_pkg::coord_t w;
    tbgf_pkg::coord_t s2;
  } axis_t;

  function automatic axis_t clip_axis(tbgf_pkg::coord_t a,
                                      logic [tbgf_pkg::BOX_W-1:0] len,
                                      logic [tbgf_pkg::BOX_W-1:0] lim,
                                      logic keep);
    tbgf_pkg::coord_t l, lm, s, ac;
    axis_t r;
    l  = tbgf_pkg::coord_t'({1'b0, len});
    lm = tbgf_pkg::coord_t'({1'b0, lim});
    s  = a + l;
    ac = a[tbgf_pkg::VW-1] ? '0 : a;
    if (keep) begin
      r.w  = l;
      r.s2 = a + s;
    end else if (s > lm) begin
      r.w  = lm - ac;
      r.s2 = ac + lm;
    end else if (a[tbgf_pkg::VW-1]) begin
      r.w  = s;
      r.s2 = s;
    end else begin
      r.w  = l;
      r.s2 = a + s;
    end
    return r;
  endfunction

  function automatic logic signed [tbgf_pkg::OUT_W-1:0] sat_out(tbgf_pkg::coord_t v);
    logic signed [SW-1:0] ve;
    ve = SW'(v);
    if (ve > SAT_HI) ve = SAT_HI;
    if (ve < SAT_LO) ve = SAT_LO;
    return ve[tbgf_pkg::OUT_W-1:0];
  endfunction

  function automatic tbgf_pkg::coord_t center(tbgf_pkg::coord_t s2,
                                              logic [tbgf_pkg::BOX_W-1:0] lim,
                                              logic inv);
    tbgf_pkg::coord_t c;
    c = tbgf_pkg::half_tz(s2) - tbgf_pkg::coord_t'({1'b0, lim} >> 1);
    return inv ? -c : c;
  endfunction

  logic                 c_vld_q, o_vld_q, c_ready, o_ready;
  tbgf_pkg::tbgf_clip_t c_q, c_d;
  tbgf_pkg::tbgf_res_t  o_q, o_d;
  axis_t                ax, ay;
  tbgf_pkg::coord_t     cx, cy, sc;

  assign o_ready      = !o_vld_q || res_o.ready;
  assign c_ready      = !c_vld_q || o_ready;
  assign desc_ready_o = c_ready;

  always_comb begin
    ax = clip_axis(desc_i.x, desc_i.w, cfg_i.frame_width, cfg_i.keep_unclamped);
    ay = clip_axis(desc_i.y, desc_i.h, cfg_i.frame_height, cfg_i.keep_unclamped);
    c_d.cw        = ax.w;
    c_d.ch        = ay.w;
    c_d.sx2       = ax.s2;
    c_d.sy2       = ay.s2;
    c_d.fnum      = desc_i.fnum;
    c_d.fo        = desc_i.fo;
    c_d.interp    = desc_i.interp;
    c_d.run_start = desc_i.run_start;
    c_d.run_end   = desc_i.run_end;
    c_d.last      = desc_i.last;
  end

  always_comb begin
    cx = center(c_q.sx2, cfg_i.frame_width, cfg_i.invert_position);
    cy = center(c_q.sy2, cfg_i.frame_height, cfg_i.invert_position);
    sc = (c_q.cw > c_q.ch) ? c_q.cw : c_q.ch;
    o_d.center_x     = sat_out(cx);
    o_d.center_y     = sat_out(cy);
    o_d.width        = sat_out(c_q.cw);
    o_d.height       = sat_out(c_q.ch);
    o_d.scale        = sat_out(sc);
    o_d.frame_number = c_q.fnum;
    o_d.found_out    = c_q.fo;
    o_d.interpolated = c_q.interp;
    o_d.run_start    = c_q.run_start;
    o_d.run_end      = c_q.run_end;
    o_d.last_out     = c_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (c_ready) begin
        c_vld_q <= desc_valid_i;
      end
      if (o_ready) begin
        o_vld_q <= c_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && desc_valid_i) begin
      c_q <= c_d;
    end
    if (o_ready && c_vld_q) begin
      o_q <= o_d;
    end
  end

  assign res_o.valid        = o_vld_q;
  assign res_o.center_x     = o_q.center_x;
  assign res_o.center_y     = o_q.center_y;
  assign res_o.width        = o_q.width;
  assign res_o.height       = o_q.height;
  assign res_o.scale        = o_q.scale;
  assign res_o.frame_number = o_q.frame_number;
  assign res_o.found_out    = o_q.found_out;
  assign res_o.interpolated = o_q.interpolated;
  assign res_o.run_start    = o_q.run_start;
  assign res_o.run_end      = o_q.run_end;
  assign res_o.last_out     = o_q.last_out;

endmodule

// ===== design/track_box_gap_fill_and_segment_top.sv =====
// Result path: a frame's result follows the item two frames later through the
//   input register, window, clip stage and result register.
// Throughput: one item per cycle while the result channel does not stall; a last
//   item holds the input while the window flushes the frames still held (up to two).
// Reset: pipeline empty, window cleared, registers at their documented defaults.
// ----------------------------------------------------------------------------
// track_box_gap_fill_and_segment_top
// Per-frame tracked box stream: single-frame gap fill, frame clipping,
// centered coordinates and found-run marks, with a flush on the last frame.
// ----------------------------------------------------------------------------
module track_box_gap_fill_and_segment_top #(
  parameter int unsigned INDEX_BITS = 20,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tbgf_in_if.sink    box_i,
  tbgf_out_if.source res_o,
  tbgf_cfg_if.sink   cfg_i
);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the block is idle;
  // the block does not enforce it. Downstream stages read these with no shadowing.
  // --------------------------------------------------------------------------
  tbgf_pkg::tbgf_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width     <= tbgf_pkg::FRAME_WIDTH_RST;
      cfg_q.frame_height    <= tbgf_pkg::FRAME_HEIGHT_RST;
      cfg_q.range_start     <= '0;
      cfg_q.keep_unclamped  <= 1'b0;
      cfg_q.invert_position <= 1'b0;
    end else if (cfg_i.valid) begin
      // Drop writes to indexes past the register list.
      case (cfg_i.index)
        tbgf_pkg::CFG_FRAME_WIDTH:     cfg_q.frame_width     <= cfg_i.data[tbgf_pkg::BOX_W-1:0];
        tbgf_pkg::CFG_FRAME_HEIGHT:    cfg_q.frame_height    <= cfg_i.data[tbgf_pkg::BOX_W-1:0];
        tbgf_pkg::CFG_RANGE_START:     cfg_q.range_start     <= cfg_i.data;
        tbgf_pkg::CFG_KEEP_UNCLAMPED:  cfg_q.keep_unclamped  <= cfg_i.data[0];
        tbgf_pkg::CFG_INVERT_POSITION: cfg_q.invert_position <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register. Register each box along with its center, so the gap fill
  // in the window only has to average two ready-made centers.
  // --------------------------------------------------------------------------
  logic                 in_vld_q;
  tbgf_pkg::tbgf_item_t in_q, in_d;
  logic                 win_ready;
  logic                 in_ready;

  assign in_ready    = !in_vld_q || win_ready;
  assign box_i.ready = in_ready;

  always_comb begin
    in_d.box.x      = tbgf_pkg::coord_t'(box_i.box_x);
    in_d.box.y      = tbgf_pkg::coord_t'(box_i.box_y);
    in_d.box.w      = box_i.box_w;
    in_d.box.h      = box_i.box_h;
    in_d.box.mx     = tbgf_pkg::mid_of(tbgf_pkg::coord_t'(box_i.box_x), box_i.box_w);
    in_d.box.my     = tbgf_pkg::mid_of(tbgf_pkg::coord_t'(box_i.box_y), box_i.box_h);
    in_d.box.found  = box_i.found;
    in_d.box.interp = 1'b0;
    in_d.last       = box_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= box_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && box_i.valid) begin
      in_q <= in_d;
    end
  end

  // --------------------------------------------------------------------------
  // Window: holds two frames, fills a lone gap, marks runs and flushes on the
  // last transaction. It hands one result descriptor per cycle downstream while the emit path is ready.
  // --------------------------------------------------------------------------
  logic                 desc_vld;
  logic                 desc_ready;
  tbgf_pkg::tbgf_desc_t desc;

  tbgf_window #(
    .INDEX_BITS (INDEX_BITS)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (in_vld_q),
    .item_i       (in_q),
    .item_ready_o (win_ready),
    .desc_valid_o (desc_vld),
    .desc_o       (desc),
    .desc_ready_i (desc_ready)
  );

  // --------------------------------------------------------------------------
  // Emit path: clip stage, then the result register that drives res_o. The
  // result register lets the window keep going while a result waits.
  // --------------------------------------------------------------------------
  tbgf_emit #(
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .desc_valid_i (desc_vld),
    .desc_i       (desc),
    .desc_ready_o (desc_ready),
    .res_o        (res_o)
  );

endmodule

// ===== tb/tb_track_box_gap_fill_and_segment_top.sv =====
// ----------------------------------------------------------------------------
// Track box gap fill and segment testbench
// Streams per-frame tracked boxes into the block, predicts each result with an
// independent model of the window, gap filling, clipping and run marks, and
// compares every result field by field under several register settings and
// idle patterns, including a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_track_box_gap_fill_and_segment_top;

  localparam int     IDX_W         = 20;
  localparam int     SETTLE_CYCLES = 12;
  localparam int     HOLD_LEN      = 200;
  localparam int     CYCLE_LIMIT   = 100000;
  localparam longint COORD_MAX     = 32767;
  localparam longint COORD_MIN     = -32768;

  // One input frame as it travels over the box channel.
  typedef struct packed {
    logic signed [tbgf_pkg::IN_COORD_W-1:0] x;
    logic signed [tbgf_pkg::IN_COORD_W-1:0] y;
    logic [tbgf_pkg::BOX_W-1:0]             w;
    logic [tbgf_pkg::BOX_W-1:0]             h;
    logic                                   found;
    logic                                   last;
  } box_item_t;

  // Held frame of the prediction window, at full precision.
  typedef struct {
    longint x;
    longint y;
    longint w;
    longint h;
    bit     interp;
  } track_box_t;

  logic clk_i;
  logic rst_ni;

  tbgf_in_if  box_if ();
  tbgf_out_if res_if ();
  tbgf_cfg_if cfg_if ();

  track_box_gap_fill_and_segment_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .box_i  (box_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Frames waiting to be offered, and results the block still owes us.
  box_item_t           pending_boxes[$];
  tbgf_pkg::tbgf_res_t expected_results[$];

  // Register copies, updated on each accepted configuration transaction.
  logic [tbgf_pkg::BOX_W-1:0]    cfg_frame_w;
  logic [tbgf_pkg::BOX_W-1:0]    cfg_frame_h;
  logic [tbgf_pkg::RSTART_W-1:0] cfg_range_start;
  logic                          cfg_keep_unclamped;
  logic                          cfg_invert;

  // Prediction window state.
  track_box_t       win_box[2];
  bit               win_found[2];
  bit               prev_found_out;
  int               win_count;
  logic [IDX_W-1:0] next_frame;

  // Idle control and the long receiver hold-off.
  int  src_idle_pct;
  int  sink_stall_pct;
  bit  pressure_on;
  int  hold_cycles;
  wire holding = pressure_on && (hold_cycles < HOLD_LEN);

  // Run statistics.
  int mismatches;
  int boxes_taken;
  int results_seen;
  int fills_seen;
  int flushes_seen;
  int in_stalls;
  int tracks_queued;
  int watch_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Center of a segment, truncating toward zero.
  function automatic longint center_of(longint a, longint len);
    return (2 * a + len) / 2;
  endfunction

  // Saturate to the signed 16 bit output range.
  function automatic logic signed [tbgf_pkg::OUT_W-1:0] sat_coord(longint v);
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return tbgf_pkg::OUT_W'(v);
  endfunction

  // A held frame counts as found if it arrived found or was filled.
  function automatic bit found_after_fill(int k);
    return win_found[k] || win_box[k].interp;
  endfunction

  // Append one frame to the pending stimulus.
  function automatic void add_pending(box_item_t b);
    pending_boxes.insert(pending_boxes.size(), b);
  endfunction

  // Clip, center and mark one frame, then queue it as an expected result.
  function automatic void emit_result(track_box_t b, bit fo, bit succ_fo,
                                      logic [IDX_W-1:0] idx, bit lst);
    longint              fw, fh, x, y, w, h, cx, cy;
    tbgf_pkg::tbgf_res_t r;
    fw = cfg_frame_w;
    fh = cfg_frame_h;
    x  = b.x;
    y  = b.y;
    w  = b.w;
    h  = b.h;
    if (!cfg_keep_unclamped) begin
      if (x < 0) begin
        w += x;
        x = 0;
      end
      if (y < 0) begin
        h += y;
        y = 0;
      end
      if (x + w > fw) w = fw - x;
      if (y + h > fh) h = fh - y;
    end
    cx = center_of(x, w) - fw / 2;
    cy = center_of(y, h) - fh / 2;
    if (cfg_invert) begin
      cx = -cx;
      cy = -cy;
    end
    r.center_x     = sat_coord(cx);
    r.center_y     = sat_coord(cy);
    r.width        = sat_coord(w);
    r.height       = sat_coord(h);
    r.scale        = sat_coord(w > h ? w : h);
    r.frame_number = {1'b0, idx} + {1'b0, cfg_range_start};
    r.found_out    = fo;
    r.interpolated = b.interp;
    r.run_start    = fo && !prev_found_out;
    r.run_end      = fo && !succ_fo;
    r.last_out     = lst;
    expected_results.insert(expected_results.size(), r);
    prev_found_out = fo;
  endfunction

  // Advance the window by one accepted frame; flush it on the last frame.
  function automatic void predict_box(box_item_t it);
    track_box_t       nb;
    logic [IDX_W-1:0] n;
    longint           nw, nh, cx, cy;
    int               k;
    n         = next_frame;
    nb.x      = $signed(it.x);
    nb.y      = $signed(it.y);
    nb.w      = it.w;
    nb.h      = it.h;
    nb.interp = 1'b0;
    if (win_count >= 2) begin
      // Lone miss between two found frames: average its neighbors.
      if (win_found[0] && !win_found[1] && it.found) begin
        nw = (win_box[0].w + nb.w) / 2;
        nh = (win_box[0].h + nb.h) / 2;
        cx = (center_of(win_box[0].x, win_box[0].w) + center_of(nb.x, nb.w)) / 2;
        cy = (center_of(win_box[0].y, win_box[0].h) + center_of(nb.y, nb.h)) / 2;
        win_box[1].x      = cx - nw / 2;
        win_box[1].y      = cy - nh / 2;
        win_box[1].w      = nw;
        win_box[1].h      = nh;
        win_box[1].interp = 1'b1;
      end
      emit_result(win_box[0], found_after_fill(0), found_after_fill(1),
                  n - IDX_W'(2), 1'b0);
      win_box[0]   = win_box[1];
      win_found[0] = win_found[1];
      win_box[1]   = nb;
      win_found[1] = it.found;
    end else begin
      win_box[win_count]   = nb;
      win_found[win_count] = it.found;
      win_count++;
    end
    next_frame = n + 1'b1;
    if (it.last) begin
      for (k = 0; k < win_count; k++) begin
        emit_result(win_box[k], found_after_fill(k),
                    (k + 1 < win_count) ? found_after_fill(k + 1) : 1'b0,
                    n - IDX_W'(win_count - 1 - k), k + 1 == win_count);
      end
      win_count      = 0;
      prev_found_out = 1'b0;
      next_frame     = '0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 30) $display("%t mismatch: %s", $realtime, what);
  endtask

  task automatic check_field(logic [tbgf_pkg::FNUM_W-1:0] fnum, string name, longint got,
                             longint want);
    if (got != want) begin
      report_mismatch($sformatf("frame %0d %s got %0d want %0d", fnum, name, got, want));
    end
  endtask

  // Monitor all three channels at the clock edge: track register writes,
  // predict on every accepted box, compare every accepted result.
  always @(posedge clk_i) begin : monitor_p
    box_item_t           taken;
    tbgf_pkg::tbgf_res_t want;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (tbgf_pkg::tbgf_cfg_reg_e'(cfg_if.index))
          tbgf_pkg::CFG_FRAME_WIDTH:
            cfg_frame_w = cfg_if.data[tbgf_pkg::BOX_W-1:0];
          tbgf_pkg::CFG_FRAME_HEIGHT:
            cfg_frame_h = cfg_if.data[tbgf_pkg::BOX_W-1:0];
          tbgf_pkg::CFG_RANGE_START:
            cfg_range_start = cfg_if.data[tbgf_pkg::RSTART_W-1:0];
          tbgf_pkg::CFG_KEEP_UNCLAMPED:
            cfg_keep_unclamped = cfg_if.data[0];
          tbgf_pkg::CFG_INVERT_POSITION:
            cfg_invert = cfg_if.data[0];
          default: ;
        endcase
      end
      if (box_if.valid && box_if.ready) begin
        taken.x     = box_if.box_x;
        taken.y     = box_if.box_y;
        taken.w     = box_if.box_w;
        taken.h     = box_if.box_h;
        taken.found = box_if.found;
        taken.last  = box_if.last;
        predict_box(taken);
        boxes_taken++;
      end else if (box_if.valid) begin
        in_stalls++;
      end
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (res_if.interpolated) fills_seen++;
        if (res_if.last_out) flushes_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("frame %0d arrived with nothing expected",
                                    res_if.frame_number));
        end else begin
          want = expected_results.pop_front();
          check_field(want.frame_number, "center_x", res_if.center_x, want.center_x);
          check_field(want.frame_number, "center_y", res_if.center_y, want.center_y);
          check_field(want.frame_number, "width", res_if.width, want.width);
          check_field(want.frame_number, "height", res_if.height, want.height);
          check_field(want.frame_number, "scale", res_if.scale, want.scale);
          check_field(want.frame_number, "frame_number", res_if.frame_number,
                      want.frame_number);
          check_field(want.frame_number, "found_out", res_if.found_out, want.found_out);
          check_field(want.frame_number, "interpolated", res_if.interpolated,
                      want.interpolated);
          check_field(want.frame_number, "run_start", res_if.run_start, want.run_start);
          check_field(want.frame_number, "run_end", res_if.run_end, want.run_end);
          check_field(want.frame_number, "last_out", res_if.last_out, want.last_out);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver, receiver and hold-off counter
  // --------------------------------------------------------------------------

  // Offer the next pending frame whenever the slot is free; keep a frame
  // steady until its transaction completes.
  always @(posedge clk_i) begin : driver_p
    box_item_t nxt;
    if (!rst_ni) begin
      box_if.valid <= 1'b0;
    end else if (!box_if.valid || box_if.ready) begin
      if (pending_boxes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = pending_boxes.pop_front();
        box_if.valid <= 1'b1;
        box_if.box_x <= nxt.x;
        box_if.box_y <= nxt.y;
        box_if.box_w <= nxt.w;
        box_if.box_h <= nxt.h;
        box_if.found <= nxt.found;
        box_if.last  <= nxt.last;
      end else begin
        box_if.valid <= 1'b0;
      end
    end
  end

  // Stall the result channel at random, and hold it off entirely during
  // the pressure window.
  always @(posedge clk_i) begin : receiver_p
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= !holding && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Count the hold-off from the moment pressure is switched on.
  always @(posedge clk_i) begin : hold_off_p
    if (!pressure_on) begin
      hold_cycles <= 0;
    end else if (hold_cycles < HOLD_LEN) begin
      hold_cycles <= hold_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  function automatic box_item_t pack_box(int x, int y, int w, int h, bit fnd, bit lst);
    box_item_t b;
    b.x     = tbgf_pkg::IN_COORD_W'(x);
    b.y     = tbgf_pkg::IN_COORD_W'(y);
    b.w     = tbgf_pkg::BOX_W'(w);
    b.h     = tbgf_pkg::BOX_W'(h);
    b.found = fnd;
    b.last  = lst;
    return b;
  endfunction

  // Mostly boxes in or around the frame, sometimes any bit pattern at all.
  function automatic box_item_t make_box(int fw, int fh, bit fnd, bit lst);
    int x, y, w, h;
    if ($urandom_range(9) < 2) begin
      x = $urandom;
      y = $urandom;
      w = $urandom;
      h = $urandom;
    end else begin
      x = int'($urandom_range(fw + 60)) - 30;
      y = int'($urandom_range(fh + 60)) - 30;
      w = ($urandom_range(4) == 0) ? $urandom_range(16383) : $urandom_range(300);
      h = ($urandom_range(4) == 0) ? $urandom_range(16383) : $urandom_range(300);
    end
    return pack_box(x, y, w, h, fnd, lst);
  endfunction

  // Queue whole tracks, each closed by a last frame. Most tracks are mostly
  // found with scattered misses, so lone gaps and runs are common; a few
  // are noise with random found flags.
  task automatic queue_tracks(int n_items, int fw, int fh);
    int left, len, k;
    bit noisy, fnd;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(1, 12);
      if (len > left) len = left;
      noisy = ($urandom_range(9) == 0);
      for (k = 0; k < len; k++) begin
        fnd = noisy ? bit'($urandom_range(1)) : ($urandom_range(3) != 0);
        add_pending(make_box(fw, fh, fnd, k == len - 1));
      end
      left -= len;
      tracks_queued++;
    end
  endtask

  // Wait until every frame is taken and every result has come back, then
  // let the pipeline settle.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_boxes.size() != 0 || box_if.valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all five registers back to back; lower valid once at the end.
  task automatic program_regs(int fw, int fh, int rs, bit nocl, bit inv);
    tbgf_pkg::tbgf_cfg_reg_e         regs[5];
    logic [tbgf_pkg::CFG_DATA_W-1:0] vals[5];
    regs = '{tbgf_pkg::CFG_FRAME_WIDTH, tbgf_pkg::CFG_FRAME_HEIGHT,
             tbgf_pkg::CFG_RANGE_START, tbgf_pkg::CFG_KEEP_UNCLAMPED,
             tbgf_pkg::CFG_INVERT_POSITION};
    vals = '{tbgf_pkg::CFG_DATA_W'(fw), tbgf_pkg::CFG_DATA_W'(fh),
             tbgf_pkg::CFG_DATA_W'(rs), tbgf_pkg::CFG_DATA_W'(nocl),
             tbgf_pkg::CFG_DATA_W'(inv)};
    foreach (regs[i]) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= regs[i];
      cfg_if.data  <= vals[i];
      do @(posedge clk_i);
      while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(int fw, int fh, int rs, bit nocl, bit inv, int src_pct,
                           int stall_pct, int n_items);
    wait_drained();
    program_regs(fw, fh, rs, nocl, inv);
    src_idle_pct   <= src_pct;
    sink_stall_pct <= stall_pct;
    queue_tracks(n_items, fw, fh);
  endtask

  initial begin : watchdog_p
    for (watch_cycles = 0; watch_cycles < CYCLE_LIMIT; watch_cycles++) @(posedge clk_i);
    $display("[track_box_gap_fill_and_segment_top] ERROR");
    $finish;
  end

  initial begin : stimulus_p
    // Known values on every input from time zero; hold reset.
    rst_ni         = 1'b0;
    box_if.valid   = 1'b0;
    box_if.box_x   = '0;
    box_if.box_y   = '0;
    box_if.box_w   = '0;
    box_if.box_h   = '0;
    box_if.found   = 1'b0;
    box_if.last    = 1'b0;
    res_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = tbgf_pkg::CFG_FRAME_WIDTH;
    cfg_if.data    = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    pressure_on    = 1'b0;

    // Registers start at their reset values.
    cfg_frame_w        = tbgf_pkg::FRAME_WIDTH_RST;
    cfg_frame_h        = tbgf_pkg::FRAME_HEIGHT_RST;
    cfg_range_start    = '0;
    cfg_keep_unclamped = 1'b0;
    cfg_invert         = 1'b0;
    win_count          = 0;
    prev_found_out     = 1'b0;
    next_frame         = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed tracks under reset defaults, no idling.
    // Lone gap with odd and negative values (truncation toward zero),
    // a box over the bottom-right corner, then a double gap that stays unfilled.
    add_pending(pack_box(-7, 3, 5, 9, 1'b1, 1'b0));
    add_pending(pack_box(100, 100, 1, 1, 1'b0, 1'b0));
    add_pending(pack_box(-2, -9, 8, 4, 1'b1, 1'b0));
    add_pending(pack_box(1900, 1070, 100, 50, 1'b1, 1'b0));
    add_pending(pack_box(10, 20, 30, 40, 1'b0, 1'b0));
    add_pending(pack_box(11, 21, 31, 41, 1'b0, 1'b0));
    add_pending(pack_box(12, 22, 32, 42, 1'b1, 1'b1));
    // One-frame track with x, width and height at their maxima and y at its minimum.
    add_pending(pack_box(32767, -32768, 16383, 16383, 1'b1, 1'b1));
    // Two-frame track with x, width and height at their minima and y at its maximum: no gap fill possible.
    add_pending(pack_box(-32768, 32767, 0, 0, 1'b0, 1'b0));
    add_pending(pack_box(-1, -1, 0, 1, 1'b1, 1'b1));
    // Alternating found and missed: back-to-back fills, three results on last.
    add_pending(pack_box(-1, -1, 0, 1, 1'b1, 1'b0));
    add_pending(pack_box(0, 0, 0, 0, 1'b0, 1'b0));
    add_pending(pack_box(-4, -6, 3, 7, 1'b1, 1'b0));
    add_pending(pack_box(5, 5, 5, 5, 1'b0, 1'b0));
    add_pending(pack_box(9, -3, 6, 2, 1'b1, 1'b1));
    // Gap filled by the last frame itself.
    add_pending(pack_box(500, 300, 64, 48, 1'b1, 1'b0));
    add_pending(pack_box(0, 0, 0, 0, 1'b0, 1'b0));
    add_pending(pack_box(520, 310, 67, 45, 1'b1, 1'b1));
    tracks_queued = 5;

    // Zero frame size, top range start, inverted centers.
    run_phase(0, 0, 20'hFFFFF, 1'b0, 1'b1, 0, 0, 30);
    // Largest frame, clipping off: centers run into saturation.
    run_phase(16383, 16383, $urandom_range(20'hFFFFF), 1'b1, 1'b0, 47, 0, 35);
    run_phase(640, 480, 1000, 1'b0, 0, 0, 47, 35);
    run_phase($urandom_range(1, 16383), $urandom_range(1, 16383),
              $urandom_range(20'hFFFFF), bit'($urandom_range(1)), bit'($urandom_range(1)),
              10, 10, 35);
    // Smallest frame, then hold the result channel off so the block fills
    // up and stalls its input while frames keep coming.
    run_phase(1, 1, 1, 1'b1, 1'b1, 0, 0, 35);
    pressure_on <= 1'b1;
    // Back to the reset values, written explicitly, with no idling.
    run_phase(tbgf_pkg::FRAME_WIDTH_RST, tbgf_pkg::FRAME_HEIGHT_RST, 0, 1'b0, 1'b0,
              0, 0, 20);

    wait_drained();
    $display("covered %0d frames in %0d tracks over 7 register settings, %0d results",
             boxes_taken, tracks_queued, results_seen);
    $display("%0d filled gaps, %0d flushes, %0d input stall cycles, %0d mismatches",
             fills_seen, flushes_seen, in_stalls, mismatches);
    if (mismatches == 0) begin
      $display("[track_box_gap_fill_and_segment_top] OK");
    end else begin
      $display("[track_box_gap_fill_and_segment_top] ERROR");
    end
    $finish;
  end

endmodule
